### hdl/adsr_pkg.sv
// ============================================================================
// adsr_pkg
// Shared types and constants for the exponential ADSR envelope generator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

    localparam int unsigned FRAC_BITS   = 22;
    localparam int unsigned LEVEL_W     = 23;
    localparam int unsigned COEFF_W     = 22;
    localparam int unsigned BASE_W      = 24;
    localparam int unsigned CFG_DATA_W  = 24;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned PROD_W      = LEVEL_W + COEFF_W;
    // base plus truncated product, with headroom for the carry and the sign
    localparam int unsigned SUM_W       = BASE_W + 2;

    localparam logic [LEVEL_W-1:0] ONE_Q22 = 23'd4194304;

    localparam logic [COEFF_W-1:0] RST_ATK_MUL        = '0;
    localparam logic [BASE_W-1:0]  RST_ATK_ADD        = 24'h400000;
    localparam logic [COEFF_W-1:0] RST_DEC_MUL        = '0;
    localparam logic [BASE_W-1:0]  RST_DEC_ADD        = '0;
    localparam logic [COEFF_W-1:0] RST_REL_MUL        = '0;
    localparam logic [BASE_W-1:0]  RST_REL_ADD        = 24'hFFFFFC;
    localparam logic [LEVEL_W-1:0] RST_SUSTAIN_TARGET = 23'd2097152;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATK_MUL        = 3'd0,
        CFG_ATK_ADD        = 3'd1,
        CFG_DEC_MUL        = 3'd2,
        CFG_DEC_ADD        = 3'd3,
        CFG_REL_MUL        = 3'd4,
        CFG_REL_ADD        = 3'd5,
        CFG_SUSTAIN_TARGET = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [COEFF_W-1:0] atk_mul;
        logic [BASE_W-1:0]  atk_add;
        logic [COEFF_W-1:0] dec_mul;
        logic [BASE_W-1:0]  dec_add;
        logic [COEFF_W-1:0] rel_mul;
        logic [BASE_W-1:0]  rel_add;
        logic [LEVEL_W-1:0] sustain_target;
    } t_cfg;

endpackage

`default_nettype wire

### hdl/adsr_trig_if.sv
// ============================================================================
// adsr_trig_if
// Trigger channel: valid/ready handshake carrying one gate bit per sample.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface adsr_trig_if;
    logic valid;
    logic ready;
    logic trigger;

    modport source (output valid, output trigger, input ready);
    modport sink   (input valid, input trigger, output ready);
endinterface

`default_nettype wire

### hdl/adsr_env_if.sv
// ============================================================================
// adsr_env_if
// Envelope channel: valid/ready handshake carrying level and phase.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface adsr_env_if;
    logic        valid;
    logic        ready;
    logic [22:0] level;
    logic [2:0]  phase;

    modport source (output valid, output level, output phase, input ready);
    modport sink   (input valid, input level, input phase, output ready);
endinterface

`default_nettype wire

### hdl/adsr_cfg.sv
// ============================================================================
// adsr_cfg
// Configuration register bank: coefficients, bases and sustain level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module adsr_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [adsr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output adsr_pkg::t_cfg                       o_cfg
);
    import adsr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ATK_MUL:        n_cfg.atk_mul        = i_cfg_wdata[COEFF_W-1:0];
                CFG_ATK_ADD:        n_cfg.atk_add        = i_cfg_wdata[BASE_W-1:0];
                CFG_DEC_MUL:        n_cfg.dec_mul        = i_cfg_wdata[COEFF_W-1:0];
                CFG_DEC_ADD:        n_cfg.dec_add        = i_cfg_wdata[BASE_W-1:0];
                CFG_REL_MUL:        n_cfg.rel_mul        = i_cfg_wdata[COEFF_W-1:0];
                CFG_REL_ADD:        n_cfg.rel_add        = i_cfg_wdata[BASE_W-1:0];
                CFG_SUSTAIN_TARGET: n_cfg.sustain_target = i_cfg_wdata[LEVEL_W-1:0];
                default: ; // unknown index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.atk_mul        <= RST_ATK_MUL;
            r_cfg.atk_add        <= RST_ATK_ADD;
            r_cfg.dec_mul        <= RST_DEC_MUL;
            r_cfg.dec_add        <= RST_DEC_ADD;
            r_cfg.rel_mul        <= RST_REL_MUL;
            r_cfg.rel_add        <= RST_REL_ADD;
            r_cfg.sustain_target <= RST_SUSTAIN_TARGET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hdl/adsr_step.sv
// ============================================================================
// adsr_step
// Envelope state and one-tick update: trigger handling, one-pole multiply-add,
// clamping and phase change, all resolved combinationally ahead of the state register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module adsr_step (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire adsr_pkg::t_cfg              i_cfg,
    input  wire logic                        i_en,
    input  wire logic                        i_trigger,
    output logic [adsr_pkg::LEVEL_W-1:0]     o_level,
    output adsr_pkg::t_phase                 o_phase
);
    import adsr_pkg::*;

    localparam logic signed [SUM_W-1:0] ONE_S  = SUM_W'(ONE_Q22);
    localparam logic signed [SUM_W-1:0] ZERO_S = '0;

    t_phase             r_phase;
    t_phase             n_phase;
    logic               r_armed;
    logic               n_armed;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;

    t_phase             eff_phase;
    logic               eff_armed;
    logic [COEFF_W-1:0] sel_coeff;
    logic [BASE_W-1:0]  sel_base;
    logic [PROD_W-1:0]  prod;
    logic signed [SUM_W-1:0] v;
    logic [LEVEL_W-1:0] sus;
    logic signed [SUM_W-1:0] sus_s;

    // trigger resolves the phase before this tick's update
    always_comb begin
        eff_phase = r_phase;
        eff_armed = r_armed;
        if (i_trigger) begin
            if (!r_armed) begin
                eff_phase = PH_ATTACK;
                eff_armed = 1'b1;
            end else if (r_phase != PH_IDLE) begin
                eff_phase = PH_RELEASE;
                eff_armed = 1'b0;
            end
        end
    end

    always_comb begin
        case (eff_phase)
            PH_ATTACK: begin
                sel_coeff = i_cfg.atk_mul;
                sel_base  = i_cfg.atk_add;
            end
            PH_DECAY: begin
                sel_coeff = i_cfg.dec_mul;
                sel_base  = i_cfg.dec_add;
            end
            default: begin
                sel_coeff = i_cfg.rel_mul;
                sel_base  = i_cfg.rel_add;
            end
        endcase
    end

    assign prod  = PROD_W'(r_level) * PROD_W'(sel_coeff);
    assign v     = {{(SUM_W-BASE_W){sel_base[BASE_W-1]}}, sel_base}
                 + {{(SUM_W-LEVEL_W){1'b0}}, prod[PROD_W-1:FRAC_BITS]};
    assign sus   = (i_cfg.sustain_target > ONE_Q22) ? ONE_Q22 : i_cfg.sustain_target;
    assign sus_s = {{(SUM_W-LEVEL_W){1'b0}}, sus};

    always_comb begin
        n_phase = eff_phase;
        n_armed = eff_armed;
        n_level = '0;
        unique case (eff_phase)
            PH_ATTACK: begin
                if (v >= ONE_S) begin
                    n_level = ONE_Q22;
                    n_phase = PH_DECAY;
                end else if (v < ZERO_S) begin
                    n_level = '0;
                end else begin
                    n_level = v[LEVEL_W-1:0];
                end
            end
            PH_DECAY: begin
                if (v <= sus_s) begin
                    n_level = sus;
                    n_phase = PH_SUSTAIN;
                end else if (v > ONE_S) begin
                    n_level = ONE_Q22;
                end else begin
                    n_level = v[LEVEL_W-1:0];
                end
            end
            PH_SUSTAIN: begin
                n_level = r_level;
                n_phase = PH_RELEASE;
            end
            PH_RELEASE: begin
                if (v <= ZERO_S) begin
                    n_level = '0;
                    n_phase = PH_IDLE;
                    n_armed = 1'b0;
                end else if (v > ONE_S) begin
                    n_level = ONE_Q22;
                end else begin
                    n_level = v[LEVEL_W-1:0];
                end
            end
            default: begin
                n_level = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_armed <= 1'b0;
            r_level <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_armed <= n_armed;
            r_level <= n_level;
        end
    end

    assign o_level = r_level;
    assign o_phase = r_phase;

    a_level_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= ONE_Q22)
        else $error("envelope level above full scale");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_level == '0)
        else $error("idle phase with nonzero level");

    a_active_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ATTACK || r_phase == PH_DECAY || r_phase == PH_SUSTAIN)
        |-> r_armed)
        else $error("attack, decay or sustain without armed flag");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_phase) && $stable(r_level) && $stable(r_armed))
        else $error("envelope state moved without an update");

    a_sustain_to_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_phase == PH_SUSTAIN && !i_trigger |=> r_phase == PH_RELEASE)
        else $error("sustain did not move to release");

endmodule

`default_nettype wire

### hdl/adsr_envelope_generator_core.sv
// ============================================================================
// adsr_envelope_generator_core
// Exponential ADSR envelope generator, one envelope sample per trigger
// transaction.
// ============================================================================
//  channel    dir  handshake           payload
//  i_trig_ch  in   valid/ready         trigger (1)
//  o_env_ch   out  valid/ready         level (23, Q1.22), phase (3)
//  i_cfg_*    in   write enable only   index (3), data (24)
//
//  one transaction per cycle sustained while the output is not stalled; an accepted
//  sample passes the input register, then the multiply-add
//  that updates the envelope state, which doubles as the output register
//  reset is synchronous, active low: phase idle, level 0, registers to defaults
//  a stall on the output freezes the state and backs up into the input register
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module adsr_envelope_generator_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    adsr_trig_if.sink                            i_trig_ch,
    adsr_env_if.source                           o_env_ch,
    input  wire logic                            i_cfg_we,
    input  wire logic [adsr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [adsr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import adsr_pkg::*;

    t_cfg               cfg;
    logic               r_in_valid;
    logic               r_in_trig;
    logic               r_out_valid;
    logic               advance;
    logic               in_take;
    logic [LEVEL_W-1:0] level;
    t_phase             phase;

    // the update runs when an input sits ready and the output slot is free
    assign advance = r_in_valid && (!r_out_valid || o_env_ch.ready);
    assign in_take = i_trig_ch.valid && i_trig_ch.ready;
    assign i_trig_ch.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_trig_ch.ready) begin
                r_in_valid <= i_trig_ch.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_env_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_trig <= i_trig_ch.trigger;
        end
    end

    adsr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    adsr_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_en      (advance),
        .i_trigger (r_in_trig),
        .o_level   (level),
        .o_phase   (phase)
    );

    assign o_env_ch.valid = r_out_valid;
    assign o_env_ch.level = level;
    assign o_env_ch.phase = phase;

endmodule

`default_nettype wire

### dv/adsr_envelope_generator_core_test.sv
// ============================================================================
// adsr_envelope_generator_core_test
// Drives trigger transactions into the envelope core and checks every level
// and phase it returns against an in-bench envelope predictor. Register
// settings change between phases while the pipeline is empty, and both
// channels idle and stall at random.
// ============================================================================
`timescale 1ns / 1ps

module adsr_envelope_generator_core_test;

    import adsr_pkg::*;

    localparam longint UNITY = 4194304;
    localparam int STALL_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [2:0]         phase;
    } t_env_sample;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    adsr_trig_if trig_ch ();
    adsr_env_if  env_ch ();

    adsr_envelope_generator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_trig_ch   (trig_ch),
        .o_env_ch    (env_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // predicted register file and envelope state
    logic [COEFF_W-1:0] atk_coeff  = RST_ATK_MUL;
    logic [BASE_W-1:0]  atk_base   = RST_ATK_ADD;
    logic [COEFF_W-1:0] dec_coeff  = RST_DEC_MUL;
    logic [BASE_W-1:0]  dec_base   = RST_DEC_ADD;
    logic [COEFF_W-1:0] rel_coeff  = RST_REL_MUL;
    logic [BASE_W-1:0]  rel_base   = RST_REL_ADD;
    logic [LEVEL_W-1:0] sus_target = RST_SUSTAIN_TARGET;
    t_phase             env_ph     = PH_IDLE;
    logic               env_armed  = 1'b0;
    logic [LEVEL_W-1:0] env_lvl    = '0;

    t_env_sample expected_env[$];
    int errors = 0;
    int quiet_cycles = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // base + truncated level*coeff, signed
    function automatic longint pole_step(input logic [BASE_W-1:0] base,
                                         input logic [COEFF_W-1:0] coeff);
        longint b;
        longint prod;
        b = longint'($signed(base));
        prod = longint'(env_lvl) * longint'(coeff);
        return b + (prod >> FRAC_BITS);
    endfunction

    function automatic t_env_sample advance_envelope(input logic trig);
        longint acc;
        longint sus_lvl;
        t_env_sample s;
        sus_lvl = (sus_target > ONE_Q22) ? UNITY : longint'(sus_target);
        if (trig) begin
            if (!env_armed) begin
                env_ph = PH_ATTACK;
                env_armed = 1'b1;
            end else if (env_ph != PH_IDLE) begin
                env_ph = PH_RELEASE;
                env_armed = 1'b0;
            end
        end
        case (env_ph)
            PH_ATTACK: begin
                acc = pole_step(atk_base, atk_coeff);
                if (acc >= UNITY) begin
                    acc = UNITY;
                    env_ph = PH_DECAY;
                end else if (acc < 0) begin
                    acc = 0;
                end
            end
            PH_DECAY: begin
                acc = pole_step(dec_base, dec_coeff);
                if (acc <= sus_lvl) begin
                    acc = sus_lvl;
                    env_ph = PH_SUSTAIN;
                end
                if (acc > UNITY) acc = UNITY;
            end
            PH_SUSTAIN: begin
                acc = longint'(env_lvl);
                env_ph = PH_RELEASE;
            end
            PH_RELEASE: begin
                acc = pole_step(rel_base, rel_coeff);
                if (acc <= 0) begin
                    acc = 0;
                    env_ph = PH_IDLE;
                    env_armed = 1'b0;
                end
                if (acc > UNITY) acc = UNITY;
            end
            default: acc = 0;
        endcase
        env_lvl = acc[LEVEL_W-1:0];
        s.level = env_lvl;
        s.phase = env_ph;
        return s;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_wdata = data;
        case (idx)
            CFG_ATK_MUL:        atk_coeff = data[COEFF_W-1:0];
            CFG_ATK_ADD:        atk_base = data[BASE_W-1:0];
            CFG_DEC_MUL:        dec_coeff = data[COEFF_W-1:0];
            CFG_DEC_ADD:        dec_base = data[BASE_W-1:0];
            CFG_REL_MUL:        rel_coeff = data[COEFF_W-1:0];
            CFG_REL_ADD:        rel_base = data[BASE_W-1:0];
            CFG_SUSTAIN_TARGET: sus_target = data[LEVEL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_trigger(input logic trig);
        while ($urandom_range(99) < src_idle_pct) begin
            trig_ch.valid = 1'b0;
            trig_ch.trigger = 1'($urandom_range(1));
            @(negedge i_clk);
        end
        trig_ch.valid = 1'b1;
        trig_ch.trigger = trig;
        do @(posedge i_clk); while (!trig_ch.ready);
        expected_env.push_back(advance_envelope(trig));
        @(negedge i_clk);
    endtask

    // pipeline is two deep; wait for the last expected result, then let it drain
    task automatic wait_quiet();
        trig_ch.valid = 1'b0;
        while (expected_env.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic test_default_cycle();
        // one-step attack, instant decay, one sustain tick, one-step release,
        // then a trigger that forces release out of decay
        send_trigger(1'b1);
        send_trigger(1'b0);
        send_trigger(1'b0);
        send_trigger(1'b0);
        send_trigger(1'b0);
        send_trigger(1'b1);
        send_trigger(1'b1);
        send_trigger(1'b0);
        wait_quiet();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_UNUSED_IDX, 24'hFFFFFF);
        // most negative attack base: attack sits at zero
        write_reg(CFG_ATK_ADD, 24'h800000);
        write_reg(CFG_ATK_MUL, 24'hFFFFFF);
        send_trigger(1'b1);
        send_trigger(1'b0);
        wait_quiet();
        // decay overshooting one is capped
        write_reg(CFG_ATK_ADD, 24'h7FFFFF);
        write_reg(CFG_DEC_ADD, 24'h7FFFFF);
        write_reg(CFG_DEC_MUL, 24'h3FFFFF);
        send_trigger(1'b0);
        send_trigger(1'b0);
        wait_quiet();
        // forced release that would climb above one is held at one
        write_reg(CFG_REL_ADD, 24'h7FFFFF);
        write_reg(CFG_REL_MUL, 24'h3FFFFF);
        send_trigger(1'b1);
        send_trigger(1'b0);
        wait_quiet();
        // retrigger from release, sustain level above one
        write_reg(CFG_DEC_ADD, 24'h800000);
        write_reg(CFG_SUSTAIN_TARGET, 24'hFFFFFF);
        send_trigger(1'b1);
        send_trigger(1'b0);
        send_trigger(1'b0);
        wait_quiet();
        write_reg(CFG_REL_ADD, 24'h800000);
        write_reg(CFG_SUSTAIN_TARGET, 24'h000000);
        send_trigger(1'b0);
        send_trigger(1'b1);
        send_trigger(1'b0);
        send_trigger(1'b0);
        send_trigger(1'b0);
        wait_quiet();
    endtask

    // coefficients and bases that let the envelope walk through every phase
    task automatic load_shaped_config();
        longint c;
        longint om;
        longint tgt;
        longint b;
        longint sus;
        c = longint'($urandom_range(0, 3774873));
        om = UNITY - c;
        tgt = longint'($urandom_range(4404019, 8388607));
        b = tgt * om / UNITY;
        write_reg(CFG_ATK_MUL, c[CFG_DATA_W-1:0]);
        write_reg(CFG_ATK_ADD, b[CFG_DATA_W-1:0]);
        sus = longint'($urandom_range(0, 4194304));
        c = longint'($urandom_range(0, 3774873));
        om = UNITY - c;
        tgt = longint'($urandom_range(20000, 2000000));
        tgt = sus - tgt;
        b = tgt * om / UNITY;
        write_reg(CFG_DEC_MUL, c[CFG_DATA_W-1:0]);
        write_reg(CFG_DEC_ADD, b[CFG_DATA_W-1:0]);
        write_reg(CFG_SUSTAIN_TARGET, sus[CFG_DATA_W-1:0]);
        c = longint'($urandom_range(0, 3774873));
        om = UNITY - c;
        tgt = longint'($urandom_range(20000, 2000000));
        tgt = -tgt;
        b = tgt * om / UNITY;
        if (b >= 0) b = -1;
        write_reg(CFG_REL_MUL, c[CFG_DATA_W-1:0]);
        write_reg(CFG_REL_ADD, b[CFG_DATA_W-1:0]);
    endtask

    task automatic load_wild_config();
        write_reg(CFG_ATK_MUL, CFG_DATA_W'($urandom));
        write_reg(CFG_ATK_ADD, CFG_DATA_W'($urandom));
        write_reg(CFG_DEC_MUL, CFG_DATA_W'($urandom));
        write_reg(CFG_DEC_ADD, CFG_DATA_W'($urandom));
        write_reg(CFG_REL_MUL, CFG_DATA_W'($urandom));
        write_reg(CFG_REL_ADD, CFG_DATA_W'($urandom));
        write_reg(CFG_SUSTAIN_TARGET, CFG_DATA_W'($urandom));
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
    endtask

    task automatic test_random_envelopes();
        int idle_pct[4];
        int stall_pct[4];
        bit noisy;
        idle_pct = '{0, 76, 0, 20};
        stall_pct = '{0, 0, 76, 20};
        for (int p = 0; p < 4; p++) begin
            src_idle_pct = idle_pct[p];
            snk_stall_pct = stall_pct[p];
            for (int blk = 0; blk < 4; blk++) begin
                wait_quiet();
                if (blk == 3) load_wild_config();
                else load_shaped_config();
                // mostly sparse gate events so notes play out, some trigger noise
                noisy = ($urandom_range(3) == 0);
                for (int n = 0; n < 40; n++) begin
                    if (noisy) send_trigger(1'($urandom_range(1)));
                    else send_trigger($urandom_range(19) == 0);
                end
            end
        end
        src_idle_pct = 0;
        snk_stall_pct = 0;
    endtask

    initial begin
        env_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            env_ch.ready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin : env_check
        t_env_sample want;
        if (i_rst_n && env_ch.valid && env_ch.ready) begin
            if (expected_env.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual level %0d phase %0d",
                         $time, env_ch.level, env_ch.phase);
                errors++;
            end else begin
                want = expected_env.pop_front();
                if (env_ch.level !== want.level) begin
                    $display("%0t: level mismatch, expected %0d, actual %0d",
                             $time, want.level, env_ch.level);
                    errors++;
                end
                if (env_ch.phase !== want.phase) begin
                    $display("%0t: phase mismatch, expected %0d, actual %0d",
                             $time, want.phase, env_ch.phase);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((trig_ch.valid && trig_ch.ready) || (env_ch.valid && env_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d transactions outstanding", $time, expected_env.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        trig_ch.valid = 1'b0;
        trig_ch.trigger = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_default_cycle();
        test_register_extremes();
        test_random_envelopes();

        wait_quiet();
        if (expected_env.size() != 0) errors++;
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
hdl/adsr_pkg.sv
hdl/adsr_trig_if.sv
hdl/adsr_env_if.sv
hdl/adsr_cfg.sv
hdl/adsr_step.sv
hdl/adsr_envelope_generator_core.sv
dv/adsr_envelope_generator_core_test.sv
